/* rtl/lcbc_pkg.sv */
// ----------------------------------------------------------------------------
// lcbc_pkg: shared definitions for the Luhn card brand check
// Widths, pipeline sizing, brand codes and prefix limits.
// ----------------------------------------------------------------------------
package lcbc_pkg;

	localparam int NUM_W          = 63;
	localparam int BIN_W          = 64;
	localparam int DIGIT_W        = 4;
	localparam int NUM_DIGITS     = 19;
	localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_STAGES     = BIN_W / BITS_PER_STAGE;
	localparam int GROUP_SIZE     = 5;
	localparam int NUM_GROUPS     = (NUM_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int SUM_W          = 8;
	localparam int MAX_MULT10     = (NUM_DIGITS * 9) / 10;
	localparam int COUNT_W        = 5;
	localparam int PREFIX_W       = 7;
	localparam int BRAND_W        = 2;
	localparam int MAX_DIGITS_DEF = 19;
	localparam int LATENCY        = NUM_STAGES + 3;

	localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
	localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd1;
	localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd2;
	localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd3;

	localparam logic [PREFIX_W-1:0] PFX_AMEX_A = 7'd34;
	localparam logic [PREFIX_W-1:0] PFX_AMEX_B = 7'd37;
	localparam logic [PREFIX_W-1:0] PFX_VISA_LO = 7'd40;
	localparam logic [PREFIX_W-1:0] PFX_VISA_HI = 7'd49;
	localparam logic [PREFIX_W-1:0] PFX_MC_LO  = 7'd51;
	localparam logic [PREFIX_W-1:0] PFX_MC_HI  = 7'd55;

	localparam logic [COUNT_W-1:0] CNT_AMEX   = 5'd15;
	localparam logic [COUNT_W-1:0] CNT_VISA_A = 5'd13;
	localparam logic [COUNT_W-1:0] CNT_VISA_B = 5'd16;
	localparam logic [COUNT_W-1:0] CNT_MC     = 5'd16;

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [SUM_W-1:0] sum_t;

	// Luhn weight of one digit; doubled digits fold their digit sum.
	function automatic logic [DIGIT_W-1:0] luhn_map(input logic [DIGIT_W-1:0] d,
			input logic dbl);
		logic [DIGIT_W:0] t;
		t = {d, 1'b0};
		if (!dbl) begin
			luhn_map = d;
		end else if (t >= 5'd10) begin
			luhn_map = DIGIT_W'(t - 5'd9);
		end else begin
			luhn_map = t[DIGIT_W-1:0];
		end
	endfunction

endpackage

/* rtl/lcbc_dabble_stage.sv */
// ----------------------------------------------------------------------------
// lcbc_dabble_stage: one binary-to-BCD pipeline stage
// Runs BITS_PER_STAGE shift-add-3 steps and registers the result.
// ----------------------------------------------------------------------------
module lcbc_dabble_stage
	import lcbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  bcd_t in_bcd,
	input  bin_t in_bin,
	output logic out_valid,
	output bcd_t out_bcd,
	output bin_t out_bin
);

	logic valid_s1;
	bcd_t bcd_s1;
	bin_t bin_s1;
	bcd_t bcd_nx;
	bin_t bin_nx;

	always_comb begin
		bcd_t b;
		bin_t r;
		b = in_bcd;
		r = in_bin;
		for (int s = 0; s < BITS_PER_STAGE; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5)
					b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
			end
			b = {b[BCD_W-2:0], r[BIN_W-1]};
			r = {r[BIN_W-2:0], 1'b0};
		end
		bcd_nx = b;
		bin_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		bcd_s1 <= bcd_nx;
		bin_s1 <= bin_nx;
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;

endmodule

/* rtl/lcbc_classify.sv */
// ----------------------------------------------------------------------------
// lcbc_classify: Luhn sum, digit count, prefix and brand
// Three register stages behind the BCD conversion.
// ----------------------------------------------------------------------------
module lcbc_classify
	import lcbc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  bcd_t                in_bcd,
	output logic                done,
	output logic [BRAND_W-1:0]  brand,
	output logic                checksum_ok,
	output logic [COUNT_W-1:0]  digit_count,
	output logic [PREFIX_W-1:0] leading_prefix
);

	// stage 1: digit weights, group sums, digit counts
	logic                valid_s1;
	sum_t                grp_s1 [NUM_GROUPS];
	logic [COUNT_W-1:0]  ncnt_s1;
	logic [COUNT_W-1:0]  cnt_s1;
	bcd_t                bcd_s1;
	sum_t                grp_nx [NUM_GROUPS];
	logic [COUNT_W-1:0]  ncnt_nx;
	logic [COUNT_W-1:0]  cnt_nx;

	always_comb begin
		logic [DIGIT_W-1:0] m;
		for (int g = 0; g < NUM_GROUPS; g++)
			grp_nx[g] = '0;
		ncnt_nx = COUNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			m = luhn_map(in_bcd[i*DIGIT_W +: DIGIT_W], (i % 2) == 1);
			if (i < MAX_DIGITS)
				grp_nx[i/GROUP_SIZE] = grp_nx[i/GROUP_SIZE] + SUM_W'(m);
			if (in_bcd[i*DIGIT_W +: DIGIT_W] != '0)
				ncnt_nx = COUNT_W'(i + 1);
		end
		if (ncnt_nx > COUNT_W'(MAX_DIGITS))
			cnt_nx = COUNT_W'(MAX_DIGITS);
		else
			cnt_nx = ncnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp_nx;
		ncnt_s1 <= ncnt_nx;
		cnt_s1  <= cnt_nx;
		bcd_s1  <= in_bcd;
	end

	// stage 2: total, mod-10 test, leading prefix
	logic                valid_s2;
	logic                ok_s2;
	logic [PREFIX_W-1:0] pfx_s2;
	logic [COUNT_W-1:0]  cnt_s2;
	logic                ok_nx;
	logic [PREFIX_W-1:0] pfx_nx;

	always_comb begin
		sum_t               total;
		logic [DIGIT_W-1:0] hi;
		logic [DIGIT_W-1:0] lo;
		total = '0;
		for (int g = 0; g < NUM_GROUPS; g++)
			total = total + grp_s1[g];
		ok_nx = 1'b0;
		for (int k = 0; k <= MAX_MULT10; k++) begin
			if (total == SUM_W'(k * 10))
				ok_nx = 1'b1;
		end
		hi = '0;
		lo = bcd_s1[DIGIT_W +: DIGIT_W];
		for (int i = 2; i < NUM_DIGITS; i++) begin
			if (ncnt_s1 == COUNT_W'(i + 1)) begin
				hi = bcd_s1[i*DIGIT_W +: DIGIT_W];
				lo = bcd_s1[(i-1)*DIGIT_W +: DIGIT_W];
			end
		end
		pfx_nx = ({3'b000, hi} << 3) + ({3'b000, hi} << 1) + {3'b000, lo};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2  <= ok_nx;
		pfx_s2 <= pfx_nx;
		cnt_s2 <= cnt_s1;
	end

	// stage 3: brand decision, output word
	logic                valid_s3;
	logic [BRAND_W-1:0]  brand_s3;
	logic                ok_s3;
	logic [COUNT_W-1:0]  cnt_s3;
	logic [PREFIX_W-1:0] pfx_s3;
	logic [BRAND_W-1:0]  brand_nx;

	always_comb begin
		brand_nx = BRAND_INVALID;
		if (ok_s2) begin
			if ((pfx_s2 == PFX_AMEX_A || pfx_s2 == PFX_AMEX_B) && cnt_s2 == CNT_AMEX)
				brand_nx = BRAND_AMEX;
			else if (pfx_s2 >= PFX_VISA_LO && pfx_s2 <= PFX_VISA_HI
					&& (cnt_s2 == CNT_VISA_A || cnt_s2 == CNT_VISA_B))
				brand_nx = BRAND_VISA;
			else if (pfx_s2 >= PFX_MC_LO && pfx_s2 <= PFX_MC_HI && cnt_s2 == CNT_MC)
				brand_nx = BRAND_MASTERCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		brand_s3 <= brand_nx;
		ok_s3    <= ok_s2;
		cnt_s3   <= cnt_s2;
		pfx_s3   <= pfx_s2;
	end

	assign done           = valid_s3;
	assign brand          = brand_s3;
	assign checksum_ok    = ok_s3;
	assign digit_count    = cnt_s3;
	assign leading_prefix = pfx_s3;

endmodule

/* rtl/luhn_card_brand_check_core.sv */
// ----------------------------------------------------------------------------
// luhn_card_brand_check_core: Luhn mod-10 check and card brand decode
// Pipeline: the result strobe (done) follows the start edge through
//   16 binary-to-BCD stages, 4 bits each, then 3 checksum/classify stages.
// Throughput: one word per cycle; busy stays low, no stalls.
// Reset: arst_n clears all stage valid bits asynchronously; data regs unreset.
// ----------------------------------------------------------------------------
module luhn_card_brand_check_core
	import lcbc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [NUM_W-1:0]    card_number,
	output logic                done,
	output logic [BRAND_W-1:0]  brand,
	output logic                checksum_ok,
	output logic [COUNT_W-1:0]  digit_count,
	output logic [PREFIX_W-1:0] leading_prefix
);

	logic stg_valid [NUM_STAGES+1];
	bcd_t stg_bcd   [NUM_STAGES+1];
	bin_t stg_bin   [NUM_STAGES];

	assign busy         = 1'b0;
	assign stg_valid[0] = start;
	assign stg_bcd[0]   = '0;
	assign stg_bin[0]   = {{(BIN_W-NUM_W){1'b0}}, card_number};

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
		if (g == NUM_STAGES - 1) begin : g_last
			lcbc_dabble_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (stg_valid[g]),
				.in_bcd    (stg_bcd[g]),
				.in_bin    (stg_bin[g]),
				.out_valid (stg_valid[g+1]),
				.out_bcd   (stg_bcd[g+1]),
				.out_bin   ()
			);
		end else begin : g_mid
			lcbc_dabble_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (stg_valid[g]),
				.in_bcd    (stg_bcd[g]),
				.in_bin    (stg_bin[g]),
				.out_valid (stg_valid[g+1]),
				.out_bcd   (stg_bcd[g+1]),
				.out_bin   (stg_bin[g+1])
			);
		end
	end

	lcbc_classify #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (stg_valid[NUM_STAGES]),
		.in_bcd         (stg_bcd[NUM_STAGES]),
		.done           (done),
		.brand          (brand),
		.checksum_ok    (checksum_ok),
		.digit_count    (digit_count),
		.leading_prefix (leading_prefix)
	);

endmodule

/* rtl/lcbc_checker.sv */
// ----------------------------------------------------------------------------
// lcbc_checker: port-level checks for the Luhn card brand check
// Result timing, digit count range and brand consistency, bound to the top level.
// ----------------------------------------------------------------------------
module lcbc_checker
	import lcbc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [BRAND_W-1:0]  brand,
	input logic                checksum_ok,
	input logic [COUNT_W-1:0]  digit_count,
	input logic [PREFIX_W-1:0] leading_prefix
);

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result word without an accepted word");

	a_brand_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brand != BRAND_INVALID) |-> checksum_ok)
		else $error("brand set on failed checksum");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (digit_count >= 5'd1 && digit_count <= 5'(NUM_DIGITS)))
		else $error("digit count out of range");

	a_amex: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brand == BRAND_AMEX) |-> (digit_count == CNT_AMEX
			&& (leading_prefix == PFX_AMEX_A || leading_prefix == PFX_AMEX_B)))
		else $error("amex brand with wrong prefix or length");

	a_visa: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brand == BRAND_VISA) |-> (leading_prefix >= PFX_VISA_LO
			&& leading_prefix <= PFX_VISA_HI
			&& (digit_count == CNT_VISA_A || digit_count == CNT_VISA_B)))
		else $error("visa brand with wrong prefix or length");

endmodule

bind luhn_card_brand_check_core lcbc_checker u_lcbc_checker (.*);
